// ----- src/chr_pkg.sv -----
// chr_pkg: shared types, constants and hash helpers for the hash ring router
// used by chr_front, chr_back, chr_rsp_fifo and consistent_hash_ring_router
// no dependencies
package chr_pkg;

   localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01B3;
   localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] FNV_PRIME_SQ = FNV_PRIME * FNV_PRIME;
   // upper part of the basis after the first xor, carried through both mixes
   localparam logic [63:0] SEED_BASE    = (FNV_BASIS & ~64'hFF) * FNV_PRIME_SQ;

   localparam logic [7:0] EMPTY_ID = 8'hFF;

   localparam int ITEM_DEPTH = 4;
   localparam int ITEM_PTR_W = $clog2(ITEM_DEPTH);
   localparam int ITEM_CNT_W = ITEM_PTR_W + 1;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_NAME  = 2'd1,
      OP_FILL  = 2'd2,
      OP_KEY   = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [7:0]  host_number;
      logic [63:0] seed;
   } chr_item_type;

   typedef struct packed {
      logic [7:0]  server_id;
      logic [15:0] ring_slot;
   } chr_rsp_type;

   // one fnv-1a step, prime multiply as shifts and adds (2^40 + 0x1b3)
   function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   // hash of the basis after the two little-endian bytes of a point number
   function automatic logic [63:0] point_seed(input logic [7:0] point);
      logic [63:0] low;
      low = {56'd0, point ^ FNV_BASIS[7:0]};
      return SEED_BASE + low * FNV_PRIME_SQ;
   endfunction

endpackage

// ----- src/chr_front.sv -----
// chr_front: accepts request transfers, classifies them and works out the run seed
// holds the short item queue towards the back end; depends on chr_pkg
module chr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_command,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic [7:0]            req_point_number,
   input  logic [7:0]            req_host_number,
   output logic                  q_valid,
   output chr_pkg::chr_item_type q_item,
   input  logic                  q_pop
);

   chr_pkg::chr_item_type                 item_mem [chr_pkg::ITEM_DEPTH];
   chr_pkg::chr_item_type                 new_item;
   logic [chr_pkg::ITEM_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [chr_pkg::ITEM_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [chr_pkg::ITEM_CNT_W-1:0]        count_ff, count_in;
   logic                                  do_push;
   logic                                  do_pop;

   assign req_full = (count_ff == chr_pkg::ITEM_CNT_W'(chr_pkg::ITEM_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_item   = item_mem[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      new_item.op          = chr_pkg::op_type'(req_command);
      new_item.data_byte   = req_data_byte;
      new_item.last_byte   = req_last_byte;
      new_item.host_number = req_host_number;
      // key runs start from point zero
      new_item.seed        = chr_pkg::point_seed(
         (new_item.op == chr_pkg::OP_NAME) ? req_point_number : 8'd0);
   end

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + chr_pkg::ITEM_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + chr_pkg::ITEM_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + chr_pkg::ITEM_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - chr_pkg::ITEM_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         item_mem[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- src/chr_rsp_fifo.sv -----
// chr_rsp_fifo: result queue between the back end and the response port
// depends on chr_pkg
module chr_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  chr_pkg::chr_rsp_type           push_data,
   output logic [chr_pkg::RSP_CNT_W-1:0]  count,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output chr_pkg::chr_rsp_type           head
);

   chr_pkg::chr_rsp_type                  rsp_mem [chr_pkg::RSP_DEPTH];
   logic [chr_pkg::RSP_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [chr_pkg::RSP_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [chr_pkg::RSP_CNT_W-1:0]         count_ff, count_in;
   logic                                  do_pop;

   assign count     = count_ff;
   assign rsp_empty = (count_ff == '0);
   assign head      = rsp_mem[rd_ptr_ff];
   assign do_pop    = rsp_pop && !rsp_empty;

   // the back end only pushes when it holds a free slot, so no full check
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + chr_pkg::RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + chr_pkg::RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + chr_pkg::RSP_CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - chr_pkg::RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/chr_back.sv -----
// chr_back: hash loop, ring table memory, clear and fill sweeps, key lookups
// takes items from chr_front and pushes results into chr_rsp_fifo; depends on chr_pkg
module chr_back #(
   parameter int MAX_RING_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [MAX_RING_BITS-1:0]       ring_mask,
   input  logic                           q_valid,
   input  chr_pkg::chr_item_type          q_item,
   output logic                           q_pop,
   input  logic [chr_pkg::RSP_CNT_W-1:0]  rsp_count,
   output logic                           rsp_push,
   output chr_pkg::chr_rsp_type           rsp_data
);

   localparam int AW    = MAX_RING_BITS;
   localparam int DEPTH = 1 << AW;

   typedef enum logic [3:0] {
      ST_RUN   = 4'b0001,
      ST_CLEAR = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FILL  = 4'b1000
   } back_state_type;

   logic [7:0]                ring_mem [DEPTH];
   logic [7:0]                mem_rd_ff;
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [7:0]                mem_wdata;
   logic [AW-1:0]             mem_raddr;

   back_state_type            state_ff, state_in;
   logic [63:0]               hash_ff, hash_in;
   logic                      in_run_ff, in_run_in;
   logic [7:0]                carried_ff, carried_in;

   logic                      b_valid_ff, b_valid_in;
   logic                      b_key_ff, b_key_in;
   logic [AW-1:0]             b_slot_ff, b_slot_in;
   logic [7:0]                b_host_ff, b_host_in;
   logic                      c_valid_ff;
   logic [AW-1:0]             c_slot_ff;

   logic [AW-1:0]             sweep_addr_ff, sweep_addr_in;
   logic                      issue_ff, issue_in;
   logic                      chk_valid_ff, chk_valid_in;
   logic [AW-1:0]             chk_addr_ff, chk_addr_in;

   logic [63:0]               hash_start;
   logic [63:0]               hash_next;
   logic [chr_pkg::RSP_CNT_W:0] key_pending;
   logic                      credit_ok;

   assign hash_start  = in_run_ff ? hash_ff : q_item.seed;
   assign hash_next   = chr_pkg::fnv_mix(hash_start, q_item.data_byte);
   assign key_pending = {1'b0, rsp_count}
                      + (chr_pkg::RSP_CNT_W + 1)'(b_valid_ff && b_key_ff)
                      + (chr_pkg::RSP_CNT_W + 1)'(c_valid_ff);
   assign credit_ok   = (key_pending < (chr_pkg::RSP_CNT_W + 1)'(chr_pkg::RSP_DEPTH));

   assign rsp_push           = c_valid_ff;
   assign rsp_data.server_id = mem_rd_ff;
   assign rsp_data.ring_slot = 16'(c_slot_ff);

   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      in_run_in     = in_run_ff;
      carried_in    = carried_ff;
      b_valid_in    = 1'b0;
      b_key_in      = b_key_ff;
      b_slot_in     = b_slot_ff;
      b_host_in     = b_host_ff;
      sweep_addr_in = sweep_addr_ff;
      issue_in      = issue_ff;
      chk_valid_in  = 1'b0;
      chk_addr_in   = chk_addr_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = sweep_addr_ff;
      mem_wdata     = chr_pkg::EMPTY_ID;
      mem_raddr     = sweep_addr_ff;

      unique case (state_ff)
         ST_RUN: begin
            mem_we    = b_valid_ff && !b_key_ff;
            mem_waddr = b_slot_ff;
            mem_wdata = b_host_ff;
            mem_raddr = b_slot_ff;
            if (q_valid) begin
               unique case (q_item.op)
                  chr_pkg::OP_CLEAR, chr_pkg::OP_FILL: begin
                     // the table walk waits for the pending lookup or placement
                     if (!b_valid_ff) begin
                        q_pop         = 1'b1;
                        in_run_in     = 1'b0;
                        issue_in      = 1'b1;
                        if (q_item.op == chr_pkg::OP_CLEAR) begin
                           state_in      = ST_CLEAR;
                           sweep_addr_in = '0;
                        end else begin
                           state_in      = ST_SCAN;
                           sweep_addr_in = ring_mask;
                        end
                     end
                  end
                  chr_pkg::OP_NAME, chr_pkg::OP_KEY: begin
                     if (!q_item.last_byte || q_item.op == chr_pkg::OP_NAME || credit_ok) begin
                        q_pop      = 1'b1;
                        hash_in    = hash_next;
                        in_run_in  = !q_item.last_byte;
                        b_valid_in = q_item.last_byte;
                        b_key_in   = (q_item.op == chr_pkg::OP_KEY);
                        b_slot_in  = hash_next[AW-1:0] & ring_mask;
                        b_host_in  = q_item.host_number;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_CLEAR: begin
            mem_we        = 1'b1;
            sweep_addr_in = sweep_addr_ff + AW'(1);
            if (sweep_addr_ff == '1) begin
               state_in = ST_RUN;
            end
         end

         ST_SCAN: begin
            // walk down from the top entry, one read ahead of the check
            if (issue_ff) begin
               chk_valid_in  = 1'b1;
               chk_addr_in   = sweep_addr_ff;
               sweep_addr_in = sweep_addr_ff - AW'(1);
               issue_in      = (sweep_addr_ff != AW'(1));
            end
            if (chk_valid_ff && (mem_rd_ff != chr_pkg::EMPTY_ID ||
                                 chk_addr_ff == AW'(1))) begin
               carried_in    = mem_rd_ff;
               state_in      = ST_FILL;
               sweep_addr_in = '0;
               issue_in      = 1'b1;
               chk_valid_in  = 1'b0;
            end
         end

         ST_FILL: begin
            // read entry i while writing back entry i-1
            mem_waddr = chk_addr_ff;
            mem_wdata = carried_ff;
            if (issue_ff) begin
               chk_valid_in  = 1'b1;
               chk_addr_in   = sweep_addr_ff;
               sweep_addr_in = sweep_addr_ff + AW'(1);
               issue_in      = (sweep_addr_ff != ring_mask);
            end
            if (chk_valid_ff) begin
               if (mem_rd_ff == chr_pkg::EMPTY_ID) begin
                  mem_we = 1'b1;
               end else begin
                  carried_in = mem_rd_ff;
               end
               if (chk_addr_ff == ring_mask) begin
                  state_in     = ST_RUN;
                  chk_valid_in = 1'b0;
               end
            end
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         hash_ff      <= '0;
         in_run_ff    <= 1'b0;
         carried_ff   <= chr_pkg::EMPTY_ID;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         issue_ff     <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         in_run_ff    <= in_run_in;
         carried_ff   <= carried_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= b_valid_ff && b_key_ff;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_key_ff      <= b_key_in;
      b_slot_ff     <= b_slot_in;
      b_host_ff     <= b_host_in;
      c_slot_ff     <= b_slot_ff;
      sweep_addr_ff <= sweep_addr_in;
      chk_addr_ff   <= chk_addr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= ring_mem[mem_raddr];
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("back state not one-hot");

   a_place_only_in_run: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> state_ff == ST_RUN)
      else $error("placement or lookup pending during a table walk");

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> rsp_count < chr_pkg::RSP_CNT_W'(chr_pkg::RSP_DEPTH))
      else $error("lookup result with no room in the result queue");

   a_chk_in_walk: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_FILL))
      else $error("walk check outside a walk");

   a_fill_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && mem_we) |-> (chk_valid_ff && mem_rd_ff == chr_pkg::EMPTY_ID))
      else $error("fill wrote an entry that was not empty");

endmodule

// ----- src/consistent_hash_ring_router.sv -----
// Consistent-hash ring router. Host points and lookup keys arrive as one byte per
// transfer and are hashed with 64-bit FNV-1a; name and key bytes are taken at one
// per cycle (the hash step is combinational) while the back end is in its run
// state and, for a closing key byte, the result queue has room. A lookup result
// reaches the result ports through the lookup stage, the ring table memory read
// and the result queue. Clear walks the whole table of 2^MAX_RING_BITS entries,
// one write per cycle; fill walks down from the top entry until a placed host is
// found (at most 2^ring_bits - 1 reads), then visits 2^ring_bits entries and
// writes the carried host into each empty one. Further transfers queue up behind a
// walk until the input queue is full. Configuration writes are to be made while
// the block is idle. Files: chr_pkg, chr_front, chr_rsp_fifo, chr_back.
module consistent_hash_ring_router #(
   parameter int MAX_RING_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [7:0]  req_point_number,
   input  logic [7:0]  req_host_number,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_server_id,
   output logic [15:0] rsp_ring_slot,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   localparam int RESET_BITS = (MAX_RING_BITS < 16) ? MAX_RING_BITS : 16;
   localparam logic [MAX_RING_BITS-1:0] RESET_MASK =
      MAX_RING_BITS'((64'd1 << RESET_BITS) - 64'd1);

   logic [MAX_RING_BITS-1:0]        ring_mask_ff, ring_mask_in;
   logic [4:0]                      eff_bits;
   logic                            q_valid;
   chr_pkg::chr_item_type           q_item;
   logic                            q_pop;
   logic [chr_pkg::RSP_CNT_W-1:0]   rsp_count;
   logic                            rsp_push;
   chr_pkg::chr_rsp_type            rsp_data;
   chr_pkg::chr_rsp_type            rsp_head;

   // ring size register kept as its index mask, clamped to 1..MAX_RING_BITS
   always_comb begin
      if (csr_wdata == 5'd0) begin
         eff_bits = 5'd1;
      end else if (csr_wdata > 5'(MAX_RING_BITS)) begin
         eff_bits = 5'(MAX_RING_BITS);
      end else begin
         eff_bits = csr_wdata;
      end
      for (int i = 0; i < MAX_RING_BITS; i++) begin
         ring_mask_in[i] = (5'(i) < eff_bits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_mask_ff <= RESET_MASK;
      end else if (csr_we) begin
         ring_mask_ff <= ring_mask_in;
      end
   end

   chr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_point_number (req_point_number),
      .req_host_number  (req_host_number),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   chr_back #(
      .MAX_RING_BITS (MAX_RING_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ring_mask (ring_mask_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   chr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .count     (rsp_count),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (rsp_head)
   );

   assign rsp_server_id = rsp_head.server_id;
   assign rsp_ring_slot = rsp_head.ring_slot;

endmodule
